// ===== hdl/spr_pkg.sv =====
// Shared types and codes for the slotted page record store.
// No dependencies; imported by the store module and its testbench.
package spr_pkg;

  // Operation codes carried by an input transaction
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_FIND   = 3'd1,
    OP_INSERT = 3'd2,
    OP_UPDATE = 3'd3,
    OP_DELETE = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NOT_FND  = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DISPATCH = 14'b00000000000010,
    S_LK_ISSUE = 14'b00000000000100,
    S_LK_CMP   = 14'b00000000001000,
    S_FOUND    = 14'b00000000010000,
    S_BYTE_RD  = 14'b00000000100000,
    S_MVB_RD   = 14'b00000001000000,
    S_MVB_WR   = 14'b00000010000000,
    S_MVD_RD   = 14'b00000100000000,
    S_MVD_WR   = 14'b00001000000000,
    S_FIN_RM   = 14'b00010000000000,
    S_APPEND   = 14'b00100000000000,
    S_COMMIT   = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

endpackage

// ===== hdl/spr_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
// Used for the byte area and the descriptor key and length stores.
module spr_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/slotted_page_record_store.sv =====
// Slotted page record store. A byte item that streams into an open record, an
// init or an unused code goes from accept through dispatch straight to the result
// state. Find, read, update and delete walk the descriptors oldest first with one
// compare unit, issuing and comparing each descriptor in turn; delete and a resizing
// update then move the tail bytes and younger descriptors, each by a read and a write.
// One transaction is in flight at a time. Synchronous reset empties the page and sets
// dirty; record and descriptor memories are not cleared.
module slotted_page_record_store #(
  parameter int USABLE_BYTES     = 4091,
  parameter int DESCRIPTOR_BYTES = 10,
  parameter int DESCRIPTOR_SLOTS = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           operation,
  input  logic [63:0]          key,
  input  logic [11:0]          record_length,
  input  logic [11:0]          byte_index,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spr_pkg::status_t     status,
  output logic [11:0]          record_offset,
  output logic [11:0]          found_length,
  output logic [7:0]           data_out,
  output logic [11:0]          free_bytes,
  output logic                 dirty
);
  import spr_pkg::*;

  localparam int OFF_W = $clog2(USABLE_BYTES + 1);
  localparam int BA_W  = $clog2(USABLE_BYTES);
  localparam int IDX_W = $clog2(DESCRIPTOR_SLOTS);
  localparam int CNT_W = $clog2(DESCRIPTOR_SLOTS + 1);
  localparam int SUM_W = ((OFF_W > 12) ? OFF_W : 12) + 1;
  localparam logic [SUM_W-1:0] DESC_COST = SUM_W'(DESCRIPTOR_BYTES);

  state_t state;

  // latched transaction
  op_t         op_q;
  logic [63:0] key_q;
  logic [11:0] rlen_q, bidx_q;
  logic [7:0]  dbyte_q;
  logic        last_q;

  // page state
  logic [CNT_W-1:0] record_count;
  logic [OFF_W-1:0] free_space, fill_end, stream_offset;
  logic [11:0]      stream_length;
  logic             stream_active, page_dirty;

  // walk state
  logic [CNT_W-1:0] idx;
  logic [OFF_W-1:0] pos, foff, mv_j;
  logic [11:0]      flen_f;

  // result accumulators
  status_t          res_status;
  logic [OFF_W-1:0] res_roff;
  logic [11:0]      res_flen;
  logic [7:0]       res_dout;

  // memory ports
  logic             b_we, d_we;
  logic [BA_W-1:0]  b_waddr, b_raddr;
  logic [7:0]       b_wdata, b_rdata;
  logic [IDX_W-1:0] d_waddr, d_raddr;
  logic [63:0]      k_wdata, k_rdata;
  logic [11:0]      l_wdata, l_rdata;

  logic [SUM_W-1:0] tail_len, src_addr, dst_addr, stream_addr, read_addr;
  logic             append_fail;

  spr_ram #(.DEPTH(USABLE_BYTES), .WIDTH(8)) u_bytes (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );
  spr_ram #(.DEPTH(DESCRIPTOR_SLOTS), .WIDTH(64)) u_keys (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(k_wdata),
    .raddr(d_raddr), .rdata(k_rdata)
  );
  spr_ram #(.DEPTH(DESCRIPTOR_SLOTS), .WIDTH(12)) u_lens (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(l_wdata),
    .raddr(d_raddr), .rdata(l_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // address arithmetic
  assign tail_len    = SUM_W'(fill_end) - SUM_W'(foff) - SUM_W'(flen_f);
  assign src_addr    = SUM_W'(foff) + SUM_W'(flen_f) + SUM_W'(mv_j);
  assign dst_addr    = SUM_W'(foff) + SUM_W'(mv_j);
  assign stream_addr = SUM_W'(stream_offset) + SUM_W'(bidx_q);
  assign read_addr   = SUM_W'(foff) + SUM_W'(bidx_q);
  assign append_fail = (record_count >= CNT_W'(DESCRIPTOR_SLOTS)) ||
                       (SUM_W'(free_space) < SUM_W'(rlen_q) + DESC_COST);

  // memory port steering
  always_comb begin
    b_we    = 1'b0;
    b_waddr = BA_W'(dst_addr);
    b_wdata = b_rdata;
    b_raddr = BA_W'(src_addr);
    d_we    = 1'b0;
    d_waddr = idx[IDX_W-1:0];
    k_wdata = k_rdata;
    l_wdata = l_rdata;
    d_raddr = idx[IDX_W-1:0];
    unique case (state)
      S_DISPATCH: begin
        b_waddr = BA_W'(stream_addr);
        b_wdata = dbyte_q;
        b_we    = ((op_q == OP_INSERT) || (op_q == OP_UPDATE)) && (bidx_q != 12'd0) &&
                  stream_active && (bidx_q < stream_length);
      end
      S_FOUND:  b_raddr = BA_W'(read_addr);
      S_MVB_WR: b_we = 1'b1;
      S_MVD_RD: d_raddr = IDX_W'(idx + CNT_W'(1));
      S_MVD_WR: d_we = 1'b1;
      S_APPEND: begin
        d_waddr = record_count[IDX_W-1:0];
        k_wdata = key_q;
        l_wdata = rlen_q;
        d_we    = !append_fail;
      end
      S_COMMIT: begin
        b_waddr = BA_W'(stream_offset);
        b_wdata = dbyte_q;
        b_we    = (rlen_q != 12'd0);
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      record_count  <= '0;
      free_space    <= OFF_W'(USABLE_BYTES);
      fill_end      <= '0;
      page_dirty    <= 1'b1;
      stream_offset <= '0;
      stream_length <= '0;
      stream_active <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q    <= op_t'(operation);
            key_q   <= key;
            rlen_q  <= record_length;
            bidx_q  <= byte_index;
            dbyte_q <= data_byte;
            last_q  <= last;
            state   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_dout <= '0;
          idx      <= '0;
          pos      <= '0;
          mv_j     <= '0;
          if (((op_q == OP_INSERT) || (op_q == OP_UPDATE)) && (bidx_q != 12'd0)) begin
            // byte inside an open stream
            state <= S_DONE;
            if (!stream_active) begin
              res_status <= ST_NO_SPACE;
              res_roff   <= '0;
              res_flen   <= '0;
            end else begin
              res_roff <= stream_offset;
              res_flen <= stream_length;
              if (bidx_q >= stream_length) begin
                res_status <= ST_RANGE;
              end else begin
                res_status <= ST_OK;
              end
              if (last_q) stream_active <= 1'b0;
            end
          end else begin
            res_status    <= ST_OK;
            res_roff      <= '0;
            res_flen      <= '0;
            stream_active <= 1'b0;
            case (op_q)
              OP_INIT: begin
                record_count  <= '0;
                free_space    <= OFF_W'(USABLE_BYTES);
                fill_end      <= '0;
                page_dirty    <= 1'b1;
                stream_offset <= '0;
                stream_length <= '0;
                state         <= S_DONE;
              end
              OP_INSERT: state <= S_APPEND;
              OP_FIND, OP_UPDATE, OP_DELETE, OP_READ: state <= S_LK_ISSUE;
              default: state <= S_DONE;
            endcase
          end
        end
        // descriptor walk, oldest first
        S_LK_ISSUE: begin
          if (idx == record_count) begin
            res_status <= ST_NOT_FND;
            state      <= S_DONE;
          end else begin
            state <= S_LK_CMP;
          end
        end
        S_LK_CMP: begin
          if (k_rdata == key_q) begin
            foff   <= pos;
            flen_f <= l_rdata;
            state  <= S_FOUND;
          end else begin
            pos   <= OFF_W'(SUM_W'(pos) + SUM_W'(l_rdata));
            idx   <= idx + CNT_W'(1);
            state <= S_LK_ISSUE;
          end
        end
        S_FOUND: begin
          case (op_q)
            OP_FIND: begin
              res_roff <= foff;
              res_flen <= flen_f;
              state    <= S_DONE;
            end
            OP_DELETE: begin
              res_roff <= foff;
              res_flen <= flen_f;
              state    <= S_MVB_RD;
            end
            OP_READ: begin
              res_roff <= foff;
              res_flen <= flen_f;
              if (bidx_q >= flen_f) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                state <= S_BYTE_RD;
              end
            end
            default: begin
              if (flen_f == rlen_q) begin
                stream_offset <= foff;
                page_dirty    <= 1'b1;
                state         <= S_COMMIT;
              end else begin
                state <= S_MVB_RD;
              end
            end
          endcase
        end
        S_BYTE_RD: begin
          res_dout <= b_rdata;
          state    <= S_DONE;
        end
        // close the gap in the byte area
        S_MVB_RD: state <= (SUM_W'(mv_j) == tail_len) ? S_MVD_RD : S_MVB_WR;
        S_MVB_WR: begin
          mv_j  <= mv_j + OFF_W'(1);
          state <= S_MVB_RD;
        end
        // shift younger descriptors down by one
        S_MVD_RD: state <= (idx + CNT_W'(1) >= record_count) ? S_FIN_RM : S_MVD_WR;
        S_MVD_WR: begin
          idx   <= idx + CNT_W'(1);
          state <= S_MVD_RD;
        end
        S_FIN_RM: begin
          record_count <= record_count - CNT_W'(1);
          fill_end     <= fill_end - OFF_W'(flen_f);
          free_space   <= OFF_W'(SUM_W'(free_space) + SUM_W'(flen_f) + DESC_COST);
          page_dirty   <= 1'b1;
          state        <= (op_q == OP_DELETE) ? S_DONE : S_APPEND;
        end
        S_APPEND: begin
          if (append_fail) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            record_count  <= record_count + CNT_W'(1);
            stream_offset <= fill_end;
            fill_end      <= OFF_W'(SUM_W'(fill_end) + SUM_W'(rlen_q));
            free_space    <= OFF_W'(SUM_W'(free_space) - SUM_W'(rlen_q) - DESC_COST);
            page_dirty    <= 1'b1;
            state         <= S_COMMIT;
          end
        end
        // open the stream and store its first byte
        S_COMMIT: begin
          stream_length <= rlen_q;
          stream_active <= !last_q;
          res_roff      <= stream_offset;
          res_flen      <= rlen_q;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            record_offset <= 12'(res_roff);
            found_length  <= res_flen;
            data_out      <= res_dout;
            free_bytes    <= 12'(free_space);
            dirty         <= page_dirty;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // space accounting stays consistent
  a_space: assert property (@(posedge clk) disable iff (rst)
    (32'(free_space) + 32'(fill_end) + 32'(record_count) * DESCRIPTOR_BYTES)
      == USABLE_BYTES)
    else $error("free space accounting broken");

  a_count: assert property (@(posedge clk) disable iff (rst)
    32'(record_count) <= DESCRIPTOR_SLOTS)
    else $error("descriptor count past slots");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(data_out)))
    else $error("stalled result changed");

endmodule

// ===== tb/slotted_page_record_store_tb.sv =====
`timescale 1ns / 100ps
// Regression bench for the slotted page record store: directed and random command streams.
// Depends on spr_pkg and the slotted_page_record_store module from the hdl folder.

// Page mirror: predicts one reply per accepted command and checks replies in order
class page_scoreboard;
  typedef struct {
    spr_pkg::status_t st;
    bit [11:0] off;
    bit [11:0] len;
    bit [7:0]  dout;
    bit [11:0] free;
    bit        dirty;
  } reply_t;

  localparam int PAGE_BYTES = 4091;
  localparam int DESC_BYTES = 10;
  localparam int SLOTS      = 512;

  bit [7:0]  page_mem[4096];
  bit        written[4096];
  bit [63:0] slot_key[SLOTS];
  int        slot_len[SLOTS];
  int        count, free_sp, fill, soff, slen;
  bit        dirty_f, streaming;
  reply_t    replies_due[$];
  int        errors;

  function new();
    count = 0; free_sp = PAGE_BYTES; fill = 0; soff = 0; slen = 0;
    dirty_f = 1; streaming = 0; errors = 0;
  endfunction

  // oldest matching descriptor, -1 when absent
  function int find_slot(bit [63:0] k, output int off);
    int pos;
    pos = 0;
    off = 0;
    for (int i = 0; i < count; i++) begin
      if (slot_key[i] == k) begin
        off = pos;
        return i;
      end
      pos += slot_len[i];
    end
    return -1;
  endfunction

  function void drop_record(int idx, int off);
    int len, tail;
    len = slot_len[idx];
    tail = fill - off - len;
    for (int i = 0; i < tail; i++) begin
      page_mem[off + i] = page_mem[off + len + i];
      written[off + i] = written[off + len + i];
    end
    for (int j = idx; j < count - 1; j++) begin
      slot_key[j] = slot_key[j + 1];
      slot_len[j] = slot_len[j + 1];
    end
    count--;
    fill -= len;
    free_sp += len + DESC_BYTES;
    for (int i = 0; i < len; i++) begin
      page_mem[fill + i] = 0;
      written[fill + i] = 0;
    end
    dirty_f = 1;
  endfunction

  function bit place_record(bit [63:0] k, int len);
    if (count >= SLOTS || free_sp < len + DESC_BYTES) return 0;
    slot_key[count] = k;
    slot_len[count] = len;
    count++;
    soff = fill;
    for (int i = 0; i < len; i++) written[fill + i] = 0;
    fill += len;
    free_sp -= len + DESC_BYTES;
    dirty_f = 1;
    return 1;
  endfunction

  // keeps reads off bytes that were never streamed in
  function bit [11:0] safe_index(bit [63:0] k, bit [11:0] bidx);
    int idx, off;
    idx = find_slot(k, off);
    if (idx < 0 || bidx >= slot_len[idx] || written[off + bidx]) return bidx;
    return slot_len[idx];
  endfunction

  function void apply_command(bit [2:0] op, bit [63:0] k, bit [11:0] rlen,
                              bit [11:0] bidx, bit [7:0] dbyte, bit lst);
    reply_t r;
    int idx, off;
    r.st = spr_pkg::ST_OK; r.off = 0; r.len = 0; r.dout = 0;
    if ((op == spr_pkg::OP_INSERT || op == spr_pkg::OP_UPDATE) && bidx != 0) begin
      // byte of an open stream
      if (!streaming) begin
        r.st = spr_pkg::ST_NO_SPACE;
      end else begin
        r.off = soff;
        r.len = slen;
        if (bidx >= slen) begin
          r.st = spr_pkg::ST_RANGE;
        end else begin
          page_mem[soff + bidx] = dbyte;
          written[soff + bidx] = 1;
        end
        if (lst) streaming = 0;
      end
    end else begin
      streaming = 0;
      case (op)
        spr_pkg::OP_INIT: begin
          count = 0; free_sp = PAGE_BYTES; fill = 0; dirty_f = 1; soff = 0; slen = 0;
        end
        spr_pkg::OP_FIND, spr_pkg::OP_DELETE, spr_pkg::OP_READ: begin
          idx = find_slot(k, off);
          if (idx < 0) begin
            r.st = spr_pkg::ST_NOT_FND;
          end else begin
            r.off = off;
            r.len = slot_len[idx];
            if (op == spr_pkg::OP_DELETE) drop_record(idx, off);
            else if (op == spr_pkg::OP_READ) begin
              if (bidx >= slot_len[idx]) r.st = spr_pkg::ST_RANGE;
              else r.dout = page_mem[off + bidx];
            end
          end
        end
        spr_pkg::OP_INSERT, spr_pkg::OP_UPDATE: begin
          if (op == spr_pkg::OP_INSERT) begin
            if (!place_record(k, rlen)) r.st = spr_pkg::ST_NO_SPACE;
          end else begin
            idx = find_slot(k, off);
            if (idx < 0) begin
              r.st = spr_pkg::ST_NOT_FND;
            end else if (slot_len[idx] == rlen) begin
              soff = off;
              dirty_f = 1;
            end else begin
              drop_record(idx, off);
              if (!place_record(k, rlen)) r.st = spr_pkg::ST_NO_SPACE;
            end
          end
          if (r.st == spr_pkg::ST_OK) begin
            slen = rlen;
            streaming = !lst;
            r.off = soff;
            r.len = rlen;
            if (rlen > 0) begin
              page_mem[soff] = dbyte;
              written[soff] = 1;
            end
          end
        end
        default: ;
      endcase
    end
    r.free = free_sp;
    r.dirty = dirty_f;
    replies_due.push_back(r);
  endfunction

  task report(string what, int got, int want);
    errors++;
    $display("mismatch %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task check_reply(spr_pkg::status_t st, bit [11:0] off, bit [11:0] len,
                   bit [7:0] dout, bit [11:0] free, bit dty);
    reply_t e;
    if (replies_due.size() == 0) begin
      report("unexpected transaction", st, 0);
      return;
    end
    e = replies_due.pop_front();
    if (st != e.st) report("status", st, e.st);
    if (off != e.off) report("record_offset", off, e.off);
    if (len != e.len) report("found_length", len, e.len);
    if (dout != e.dout) report("data_out", dout, e.dout);
    if (free != e.free) report("free_bytes", free, e.free);
    if (dty != e.dirty) report("dirty", dty, e.dirty);
  endtask
endclass

module slotted_page_record_store_tb;
  import spr_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [2:0]  operation;
  logic [63:0] key;
  logic [11:0] record_length, byte_index;
  logic [7:0]  data_byte;
  logic        last;
  status_t     status;
  logic [11:0] record_offset, found_length, free_bytes;
  logic [7:0]  data_out;
  logic        dirty;

  page_scoreboard page_sb;
  bit [63:0] key_pool[10];
  int  sent, received;
  bit  calm;

  slotted_page_record_store dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .key(key), .record_length(record_length),
    .byte_index(byte_index), .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .record_offset(record_offset), .found_length(found_length),
    .data_out(data_out), .free_bytes(free_bytes), .dirty(dirty)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // one command transaction; entered and left at a falling edge
  task send(bit [2:0] op, bit [63:0] k, bit [11:0] rlen, bit [11:0] bidx,
            bit [7:0] dbyte, bit lst);
    int gap;
    if (op == OP_READ) bidx = page_sb.safe_index(k, bidx);
    operation = op; key = k; record_length = rlen;
    byte_index = bidx; data_byte = dbyte; last = lst;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    page_sb.apply_command(op, k, rlen, bidx, dbyte, lst);
    sent++;
    @(negedge clk);
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function bit [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // full record stream: first byte at index zero, then the rest
  task stream_record(bit [2:0] op, bit [63:0] k, int len);
    send(op, k, len, 0, $urandom, len <= 1);
    for (int i = 1; i < len; i++)
      send(op, rand_key(), $urandom, i, $urandom, i == len - 1);
  endtask

  // result sink with random holds and one long hold-off
  initial begin
    int w;
    bit held;
    held = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!held && received >= 300) begin
        held = 1;
        out_stall = 1;
        repeat (400) @(negedge clk);
      end
      w = calm ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_stall = 1;
        repeat (w) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // sample accepted results
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      page_sb.check_reply(status, record_offset, found_length, data_out, free_bytes, dirty);
      received++;
    end
  end

  initial begin
    #1000000000;
    $display("slotted_page_record_store regression: fail");
    $finish;
  end

  initial begin
    int pick, len, r, n;
    bit [63:0] k;
    bit drained;
    page_sb = new();
    sent = 0; received = 0; calm = 0; drained = 0;
    rst = 1; in_valid = 0; operation = 0; key = 0; record_length = 0;
    byte_index = 0; data_byte = 0; last = 0;
    key_pool[0] = 0;
    key_pool[1] = '1;
    for (int i = 2; i < 10; i++) key_pool[i] = rand_key();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty page, absent keys, orphan byte, both key extremes
    send(OP_FIND, 64'd5, 0, 0, 0, 0);
    send(OP_READ, 64'd5, 0, 0, 0, 0);
    send(OP_DELETE, 64'd5, 0, 0, 0, 0);
    send(OP_UPDATE, 64'd5, 3, 0, 8'hff, 0);
    send(OP_INSERT, 64'd5, 3, 5, 8'h55, 0);
    send(OP_INSERT, 64'd0, 0, 0, 8'h00, 1);
    stream_record(OP_INSERT, '1, 3);
    send(OP_FIND, 64'd0, 0, 0, 0, 0);
    send(OP_READ, '1, 0, 2, 0, 0);
    send(OP_READ, '1, 0, 3, 0, 0);
    send(OP_READ, '1, 0, 12'hfff, 0, 0);
    stream_record(OP_UPDATE, '1, 3);
    stream_record(OP_UPDATE, 64'd0, 2);
    send(OP_READ, 64'd0, 0, 1, 0, 0);
    send(OP_DELETE, '1, 0, 0, 0, 0);
    send(3'd6, rand_key(), 12'hfff, 0, 8'hff, 1);
    send(3'd7, rand_key(), 0, 0, 0, 0);
    send(OP_INIT, 0, 0, 0, 0, 0);
    // largest record with its first and final bytes, then a full page
    send(OP_INSERT, key_pool[2], 4081, 0, $urandom, 0);
    send(OP_INSERT, rand_key(), 0, 4080, $urandom, 1);
    send(OP_INSERT, key_pool[3], 0, 0, 0, 1);
    send(OP_READ, key_pool[2], 0, 4080, 0, 0);
    send(OP_DELETE, key_pool[2], 0, 0, 0, 0);
    send(OP_INSERT, key_pool[3], 4091, 0, 0, 1);
    send(OP_INIT, 0, 0, 0, 0, 0);

    while (sent < 1650) begin
      calm = (sent > 1300 && sent < 1450);
      if (!drained && sent > 1200) begin
        // pause until the pipe is drained
        drained = 1;
        while (page_sb.replies_due.size() > 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, 9)];
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 600) : $urandom_range(0, 24);
      if (page_sb.free_sp < 500 && pick < 50) pick = 72;
      if (pick < 35) begin
        stream_record(OP_INSERT, k, len);
      end else if (pick < 50) begin
        if (page_sb.count > 0 && $urandom_range(0, 1))
          k = page_sb.slot_key[$urandom_range(0, page_sb.count - 1)];
        stream_record(OP_UPDATE, k, len);
      end else if (pick < 62) begin
        if (page_sb.count > 0) begin
          r = $urandom_range(0, page_sb.count - 1);
          k = page_sb.slot_key[r];
          len = page_sb.slot_len[r];
        end
        send(OP_READ, k, $urandom, $urandom_range(0, len + 1), $urandom, $urandom);
      end else if (pick < 70) begin
        send(OP_FIND, k, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 78) begin
        if (page_sb.count > 0 && $urandom_range(0, 1))
          k = page_sb.slot_key[$urandom_range(0, page_sb.count - 1)];
        send(OP_DELETE, k, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 80) begin
        send(OP_INIT, rand_key(), $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 88) begin
        // broken stream: cut short or indexed past the end
        len = $urandom_range(2, 12);
        send($urandom_range(0, 1) ? OP_INSERT : OP_UPDATE, k, len, 0, $urandom, 0);
        n = $urandom_range(0, len - 1);
        for (int i = 1; i <= n; i++)
          send(OP_INSERT, rand_key(), $urandom, ($urandom_range(0, 3) == 0) ? $urandom : i,
               $urandom, 0);
      end else begin
        send($urandom_range(1, 7), $urandom_range(0, 1) ? rand_key() : k, $urandom,
             $urandom, $urandom, $urandom);
      end
    end
    in_valid = 0;

    while (page_sb.replies_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (page_sb.errors == 0 && page_sb.replies_due.size() == 0)
      $display("slotted_page_record_store regression: pass");
    else
      $display("slotted_page_record_store regression: fail");
    $finish;
  end
endmodule
